// ===== sv/sgmpa_pkg.sv =====
// ----------------------------------------------------------------------------
// sgmpa_pkg
// Shared types and constants for the SGM scanline path aggregation block.
// ----------------------------------------------------------------------------
`default_nettype none

package sgmpa_pkg;

    localparam int COST_W     = 16;   // match cost field
    localparam int INT_W      = 16;   // pixel intensity field
    localparam int PATH_W     = 17;   // path cost field
    localparam int DIDX_W     = 6;    // disparity index field
    localparam int PEN_W      = 16;   // penalty registers
    localparam int CNT_CFG_W  = 7;    // disparity count register
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_STEPS  = PEN_W;

    localparam logic [PATH_W-1:0] PATH_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_SMALL   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_LARGE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LARGE     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPARITY_COUNT = 8'd3;

    // configuration reset values
    localparam logic [PEN_W-1:0]     RST_PENALTY_SMALL   = 16'd8;
    localparam logic [PEN_W-1:0]     RST_PENALTY_LARGE   = 16'd32;
    localparam logic [CNT_CFG_W-1:0] RST_DISPARITY_COUNT = 7'd64;

    typedef struct packed {
        logic [COST_W-1:0] match_cost;
        logic [INT_W-1:0]  pixel_intensity;
        logic              row_start;
    } t_in_item;

    typedef struct packed {
        logic [PATH_W-1:0] path_cost;
        logic [DIDX_W-1:0] disparity_index;
        logic              pixel_done;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PEN,
        S_CALC
    } t_state;

endpackage

`default_nettype wire

// ===== sv/sgm_scanline_path_aggregation.sv =====
// ----------------------------------------------------------------------------
// sgm_scanline_path_aggregation
// Left-to-right SGM path cost aggregation over one image row, one cost
// element (pixel, disparity) per item, path vector held in a local RAM.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        sink       i_in_valid/o_in_stall  i_in_item  (t_in_item)
// out       source     o_out_valid/i_out_stall o_out_item (t_out_item)
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Sequence: accept in S_IDLE, compute and write back in S_CALC; the
//   next item waits for S_IDLE. With gradient scaling on, disparity zero
//   first runs S_DIV (one quotient bit per cycle) and the S_PEN fix-up.
// Reset: synchronous, active low; clears control and config. The path RAM
//   is not cleared; the first pixel of a row never reads it.
// Stalls: a result waits in the output register while the next item is
//   taken; compute holds only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_scanline_path_aggregation
    import sgmpa_pkg::*;
#(
    parameter int MAX_DISPARITIES = 64,
    parameter int COST_BITS       = 16
) (
    input  wire  logic                  i_clk,
    input  wire  logic                  i_rst_n,
    // item input
    input  wire  logic                  i_in_valid,
    output logic                        o_in_stall,
    input  wire  t_in_item              i_in_item,
    // result output
    output logic                        o_out_valid,
    input  wire  logic                  i_out_stall,
    output t_out_item                   o_out_item,
    // configuration writes
    input  wire  logic                  i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // disparity address width and count width (count must hold MAX itself)
    localparam int DW   = (MAX_DISPARITIES > 1) ? $clog2(MAX_DISPARITIES) : 1;
    localparam int CW0  = $clog2(MAX_DISPARITIES + 1);
    localparam int KW   = (CW0 > CNT_CFG_W) ? CW0 : CNT_CFG_W;
    localparam logic [KW-1:0] MAX_K = KW'(MAX_DISPARITIES);
    // cost saturation limit, compared in a width that holds 2^24
    localparam int SW = 25;
    localparam logic [SW-1:0] COST_MAX = SW'((64'd1 << COST_BITS) - 64'd1);
    localparam logic [$clog2(DIV_STEPS)-1:0] DIV_LAST = ($clog2(DIV_STEPS))'(DIV_STEPS - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PEN_W-1:0]     r_cfg_small;
    logic [PEN_W-1:0]     r_cfg_large;
    logic                 r_cfg_scale;
    logic [CNT_CFG_W-1:0] r_cfg_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_small <= RST_PENALTY_SMALL;
            r_cfg_large <= RST_PENALTY_LARGE;
            r_cfg_scale <= 1'b0;
            r_cfg_count <= RST_DISPARITY_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PENALTY_SMALL:   r_cfg_small <= i_cfg_data;
                CFG_PENALTY_LARGE:   r_cfg_large <= i_cfg_data;
                CFG_SCALE_LARGE:     r_cfg_scale <= i_cfg_data[0];
                CFG_DISPARITY_COUNT: r_cfg_count <= i_cfg_data[CNT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [DW-1:0]     r_d;          // disparity counter
    logic              r_first;      // first pixel of row: output = cost
    logic [PATH_W-1:0] r_prev_min;   // minimum of previous pixel's vector
    logic [PATH_W-1:0] r_run_min;    // running minimum of this pixel
    logic [INT_W-1:0]  r_prev_int;
    logic [PEN_W-1:0]  r_p1;         // active penalties for this pixel
    logic [PEN_W-1:0]  r_p2;
    logic [PATH_W-1:0] r_held;       // previous pixel's cost at d-1
    logic [COST_W-1:0] r_cost;       // latched item cost

    // penalty divider
    logic [INT_W:0]                  r_grad;
    logic [PEN_W-1:0]                r_div_q;   // numerator in, quotient out
    logic [INT_W:0]                  r_div_rem;
    logic [$clog2(DIV_STEPS)-1:0]    r_div_cnt;

    // output register
    logic      r_out_valid;
    t_out_item r_out_item;

    logic in_acc, out_free, calc_fire, div_done;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign div_done = (r_div_cnt == DIV_LAST);

    // ------------------------------------------------------------------
    // Path RAM: one write port, two registered read ports (d and d+1).
    // Reads relaunch every cycle from r_d; r_d only moves at the write
    // edge, so the data seen in S_CALC was read after the previous
    // write-back had landed and no bypass is needed.
    // ------------------------------------------------------------------
    logic [PATH_W-1:0] r_mem [MAX_DISPARITIES];
    logic [PATH_W-1:0] r_rd_a, r_rd_b;
    logic [DW-1:0]     addr_b;
    logic [KW-1:0]     d_next_k, cnt_k;
    logic              b_valid, last_d;
    logic [PATH_W-1:0] calc_val;

    always_comb begin
        if (r_cfg_count == '0) begin
            cnt_k = KW'(1);
        end else if (KW'(r_cfg_count) > MAX_K) begin
            cnt_k = MAX_K;
        end else begin
            cnt_k = KW'(r_cfg_count);
        end
        d_next_k = KW'(r_d) + KW'(1);
        last_d   = (d_next_k >= cnt_k);
        b_valid  = (d_next_k < cnt_k);
        addr_b   = (d_next_k < MAX_K) ? DW'(d_next_k) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (calc_fire) begin
            r_mem[r_d] <= calc_val;
        end
        r_rd_a <= r_mem[r_d];
        r_rd_b <= r_mem[addr_b];
    end

    // ------------------------------------------------------------------
    // Element cost: C + min(Lp[d], Lp[d-1]+P1, Lp[d+1]+P1, minLp+P2) - minLp
    // ------------------------------------------------------------------
    logic [PATH_W:0]   t_self, t_lo, t_hi, t_jump, m_a, m_b, m_all, diff, sum;
    logic [SW-1:0]     c_ext;
    logic [COST_W-1:0] c_sat;

    always_comb begin
        c_ext  = SW'(r_cost);
        c_sat  = (c_ext > COST_MAX) ? COST_W'(COST_MAX) : r_cost;
        t_self = {1'b0, r_rd_a};
        t_lo   = (r_d != '0) ? ({1'b0, r_held} + (PATH_W+1)'(r_p1)) : '1;
        t_hi   = b_valid ? ({1'b0, r_rd_b} + (PATH_W+1)'(r_p1)) : '1;
        t_jump = {1'b0, r_prev_min} + (PATH_W+1)'(r_p2);
        m_a    = (t_self < t_lo) ? t_self : t_lo;
        m_b    = (t_hi < t_jump) ? t_hi : t_jump;
        m_all  = (m_a < m_b) ? m_a : m_b;
        diff   = (m_all > {1'b0, r_prev_min}) ? (m_all - {1'b0, r_prev_min}) : '0;
        sum    = (PATH_W+1)'(c_sat) + diff;
        if (r_first) begin
            calc_val = PATH_W'(c_sat);
        end else if (sum > {1'b0, PATH_MAX}) begin
            calc_val = PATH_MAX;
        end else begin
            calc_val = sum[PATH_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Penalty divider step: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [INT_W+1:0]  trial;
    logic              ge;
    logic [INT_W:0]    n_div_rem;
    logic [PEN_W-1:0]  n_div_q;
    logic [PEN_W-1:0]  p2_scaled, p2_dec, p1_scaled;
    logic [INT_W-1:0]  abs_grad;

    always_comb begin
        trial     = {r_div_rem, r_div_q[PEN_W-1]};
        ge        = (trial >= {1'b0, r_grad});
        n_div_rem = ge ? (INT_W+1)'(trial - {1'b0, r_grad}) : (INT_W+1)'(trial);
        n_div_q   = {r_div_q[PEN_W-2:0], ge};
        // ceil: bump the quotient on a nonzero remainder
        p2_scaled = r_div_q + PEN_W'(r_div_rem != '0);
        p2_dec    = (p2_scaled == '0) ? '0 : (p2_scaled - PEN_W'(1));
        p1_scaled = (r_cfg_small < p2_dec) ? r_cfg_small : p2_dec;
        abs_grad  = (i_in_item.pixel_intensity > r_prev_int)
                  ? (i_in_item.pixel_intensity - r_prev_int)
                  : (r_prev_int - i_in_item.pixel_intensity);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = ((r_d == '0) && r_cfg_scale) ? S_DIV : S_CALC;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PEN;
                end
            end
            S_PEN: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        calc_fire  = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_CALC:  calc_fire  = out_free;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and pixel state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_d        <= '0;
            r_first    <= 1'b1;
            r_prev_min <= '0;
            r_run_min  <= PATH_MAX;
            r_prev_int <= '0;
            r_p1       <= '0;
            r_p2       <= '0;
            r_held     <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc && (r_d == '0)) begin
                // pixel start: roll minima, latch penalties
                r_first    <= r_first | i_in_item.row_start;
                r_prev_min <= r_run_min;
                r_run_min  <= PATH_MAX;
                r_prev_int <= i_in_item.pixel_intensity;
                r_held     <= '0;
                r_p1       <= r_cfg_small;
                r_p2       <= r_cfg_large;
            end
            if (r_state == S_PEN) begin
                r_p1 <= p1_scaled;
                r_p2 <= p2_scaled;
            end
            if (calc_fire) begin
                r_held    <= r_rd_a;
                r_run_min <= (calc_val < r_run_min) ? calc_val : r_run_min;
                if (last_d) begin
                    r_d     <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_d <= DW'(d_next_k);
                end
            end
        end
    end

    // item latch and divider datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cost    <= i_in_item.match_cost;
            r_grad    <= (INT_W+1)'(abs_grad) + (INT_W+1)'(1);
            r_div_q   <= r_cfg_large;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_div_q   <= n_div_q;
            r_div_rem <= n_div_rem;
            r_div_cnt <= r_div_cnt + ($clog2(DIV_STEPS))'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (calc_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_fire) begin
            r_out_item.path_cost       <= calc_val;
            r_out_item.disparity_index <= DIDX_W'(r_d);
            r_out_item.pixel_done      <= last_d;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ===== sv/sgmpa_checker.sv =====
// ----------------------------------------------------------------------------
// sgmpa_port_checks
// Port-level checks for the SGM path aggregation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sgmpa_port_checks
    import sgmpa_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_in_item              i_in_item,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_out_item             o_out_item,
    input wire logic                  i_cfg_valid,
    input wire logic                  o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              in_acc, out_acc;
    logic [1:0]        r_pending;
    logic [DIDX_W-1:0] r_exp_idx;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // items taken but not yet delivered; expected next disparity index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_exp_idx <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
            if (out_acc) begin
                r_exp_idx <= o_out_item.pixel_done ? '0
                           : (o_out_item.disparity_index + DIDX_W'(1));
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_out_item.disparity_index == r_exp_idx)
        else $error("disparity index out of sequence");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pending != 2'd0)
        else $error("result without a pending item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !out_acc |-> r_pending != 2'd2)
        else $error("more than two items in flight");

endmodule

bind sgm_scanline_path_aggregation sgmpa_port_checks u_sgmpa_port_checks (.*);

`default_nettype wire

// ===== tb/sgmpa_checker.sv =====
// ----------------------------------------------------------------------------
// sgmpa_checker
// Watches the item, result and register channels of the SGM scanline path
// aggregation block, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sgmpa_checker
    import sgmpa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DISP_MAX    = 1 << DIDX_W;
    localparam int MAX_REPORTS = 30;

    // register copies
    logic [PEN_W-1:0]     pen_small;
    logic [PEN_W-1:0]     pen_large;
    logic                 scale_on;
    logic [CNT_CFG_W-1:0] disp_cnt;

    // path state
    logic [PATH_W-1:0] prev_cost [DISP_MAX];
    logic [PATH_W-1:0] prev_min;
    logic [PATH_W-1:0] run_min;
    logic [PATH_W-1:0] held_below;
    logic [INT_W-1:0]  prev_int;
    logic [PEN_W-1:0]  act_small;
    logic [PEN_W-1:0]  act_large;
    int unsigned       disp_ctr;
    logic              first_px;

    t_out_item path_cost_q [$];
    t_out_item predicted;
    t_out_item oldest;
    int        n_errors  = 0;
    int        n_checked = 0;
    int        n_pending = 0;

    assign o_errors  = n_errors;
    assign o_checked = n_checked;
    assign o_pending = n_pending;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (n_errors < MAX_REPORTS)
            $display("%0t: mismatch on %s: got %0d, expected %0d (result %0d)",
                     $time, what, got, want, n_checked);
        n_errors++;
    endtask

    // One aggregation step, left-to-right path.
    task automatic aggregate_cost(input t_in_item it, output t_out_item res);
        int unsigned cnt, grad, p1, p2, m, alt, diff, r, d;
        cnt = 32'(disp_cnt);
        if (cnt == 0)
            cnt = 1;
        if (cnt > DISP_MAX)
            cnt = DISP_MAX;
        if (disp_ctr == 0) begin
            p1 = 32'(pen_small);
            p2 = 32'(pen_large);
            if (scale_on) begin
                grad = (it.pixel_intensity > prev_int ? it.pixel_intensity - prev_int
                                                      : prev_int - it.pixel_intensity) + 1;
                p2 = (p2 + grad - 1) / grad;
                if (p2 == 0)
                    p1 = 0;
                else if (p2 - 1 < p1)
                    p1 = p2 - 1;
            end
            act_small  = PEN_W'(p1);
            act_large  = PEN_W'(p2);
            first_px   = first_px | it.row_start;
            prev_min   = run_min;
            run_min    = PATH_MAX;
            prev_int   = it.pixel_intensity;
            held_below = '0;
        end
        d = disp_ctr;
        if (first_px) begin
            r = 32'(it.match_cost);
        end else begin
            m = 32'(prev_cost[DIDX_W'(d)]);
            if (d > 0) begin
                alt = 32'(held_below) + 32'(act_small);
                if (alt < m)
                    m = alt;
            end
            if (d + 1 < cnt) begin
                alt = 32'(prev_cost[DIDX_W'(d + 1)]) + 32'(act_small);
                if (alt < m)
                    m = alt;
            end
            alt = 32'(prev_min) + 32'(act_large);
            if (alt < m)
                m = alt;
            // a stale entry can undercut the previous minimum after a count change
            diff = (m > 32'(prev_min)) ? m - 32'(prev_min) : 0;
            r = 32'(it.match_cost) + diff;
        end
        if (r > 32'(PATH_MAX))
            r = 32'(PATH_MAX);
        held_below   = prev_cost[DIDX_W'(d)];
        prev_cost[DIDX_W'(d)] = PATH_W'(r);
        if (r < 32'(run_min))
            run_min = PATH_W'(r);
        res.path_cost       = PATH_W'(r);
        res.disparity_index = DIDX_W'(d);
        res.pixel_done      = (d + 1 >= cnt);
        if (res.pixel_done) begin
            disp_ctr = 0;
            first_px = 1'b0;
        end else begin
            disp_ctr = d + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pen_small = RST_PENALTY_SMALL;
            pen_large = RST_PENALTY_LARGE;
            scale_on  = 1'b0;
            disp_cnt  = RST_DISPARITY_COUNT;
            prev_min  = '0;
            run_min   = PATH_MAX;
            held_below = '0;
            prev_int  = '0;
            act_small = '0;
            act_large = '0;
            disp_ctr  = 0;
            first_px  = 1'b1;
            path_cost_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PENALTY_SMALL:   pen_small = i_cfg_data;
                    CFG_PENALTY_LARGE:   pen_large = i_cfg_data;
                    CFG_SCALE_LARGE:     scale_on  = i_cfg_data[0];
                    CFG_DISPARITY_COUNT: disp_cnt  = i_cfg_data[CNT_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                aggregate_cost(i_in_item, predicted);
                path_cost_q.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (path_cost_q.size() == 0) begin
                    report_mismatch("result with none pending", i_out_item.path_cost, 0);
                end else begin
                    oldest = path_cost_q.pop_front();
                    if (i_out_item.path_cost !== oldest.path_cost)
                        report_mismatch("path_cost", i_out_item.path_cost, oldest.path_cost);
                    if (i_out_item.disparity_index !== oldest.disparity_index)
                        report_mismatch("disparity_index", i_out_item.disparity_index,
                                        oldest.disparity_index);
                    if (i_out_item.pixel_done !== oldest.pixel_done)
                        report_mismatch("pixel_done", i_out_item.pixel_done,
                                        oldest.pixel_done);
                    n_checked++;
                end
            end
        end
        n_pending = path_cost_q.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_sgm_scanline_path_aggregation.sv =====
// ----------------------------------------------------------------------------
// tb_sgm_scanline_path_aggregation
// Drives cost items and register writes into the path aggregation block:
// a short directed pass over the corner cases, then random pixels under
// many penalty and disparity-count settings with random stalls on both
// channels. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sgm_scanline_path_aggregation;
    import sgmpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS        = 1750;
    localparam int DISP_MAX       = 1 << DIDX_W;
    localparam int DRAIN_CYCLES   = 8;      // pipeline depth plus margin
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any handshake
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;  // no register here

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int errors;
    int checked;

    // Stimulus-side view of where the block stands. Needed only to keep the
    // path RAM legal: a non-first pixel must never read an entry that was
    // never written since reset.
    int   disp_pos   = 0;   // disparity of the next item
    int   cnt_use    = DISP_MAX;
    int   written_hi = 0;   // entries 0 .. written_hi-1 hold data
    logic first_trk  = 1'b1;

    logic             dense    = 1'b0;   // sender offers back to back
    logic             hold_req = 1'b0;   // receiver long hold-off request
    logic [INT_W-1:0] last_int = '0;
    int               n_items  = 0;
    int               n_pixels = 0;
    int               n_writes = 0;
    int               n_holds  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sgm_scanline_path_aggregation dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sgmpa_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_checked   (checked)
    );

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // Costs: mostly small so the neighbor and penalty terms compete.
    function automatic logic [COST_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return COST_W'($urandom_range(0, 63));
        else if (r < 85)
            return COST_W'($urandom_range(0, 1023));
        else if (r < 95)
            return COST_W'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? '1 : '0;
    endfunction

    function automatic logic [PEN_W-1:0] pick_penalty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        else if (r < 25)
            return '1;
        else if (r < 70)
            return PEN_W'($urandom_range(1, 40));
        return PEN_W'($urandom_range(0, 65535));
    endfunction

    // Disparity count: small widths dominate, out-of-range codes included.
    function automatic logic [CNT_CFG_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return CNT_CFG_W'($urandom_range(1, 8));
        else if (r < 80)
            return CNT_CFG_W'($urandom_range(9, 32));
        else if (r < 88)
            return CNT_CFG_W'(DISP_MAX);
        else if (r < 93)
            return '0;
        else if (r < 97)
            return CNT_CFG_W'($urandom_range(DISP_MAX + 1, 126));
        return '1;
    endfunction

    function automatic int count_used(input logic [CNT_CFG_W-1:0] code);
        if (code == 0)
            return 1;
        if (code > DISP_MAX)
            return DISP_MAX;
        return 32'(code);
    endfunction

    // Pixel intensity: often close to the last one, so the gradient scaling
    // sees small divisors as well as huge ones.
    function automatic logic [INT_W-1:0] next_intensity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            last_int = INT_W'(last_int + $urandom_range(0, 6) - 3);
        else if (r < 50)
            last_int = $urandom_range(0, 1) ? '1 : '0;
        else
            last_int = INT_W'($urandom_range(0, 65535));
        return last_int;
    endfunction

    // Offer one item and wait until it is taken. The valid and payload change
    // only on the falling edge, one assignment per edge.
    task automatic feed(input logic [COST_W-1:0] cost, input logic [INT_W-1:0] inten,
                        input logic rs);
        t_in_item it;
        int       gap;
        // a non-first pixel reads the vector up to the count in use; where
        // that runs past what was ever written, open a new row instead
        if (disp_pos == 0 && !first_trk && cnt_use > written_hi)
            rs = 1'b1;
        if (disp_pos == 0)
            first_trk = first_trk | rs;
        it.match_cost      = cost;
        it.pixel_intensity = inten;
        it.row_start       = rs;
        gap = dense ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        n_items++;
        if (disp_pos + 1 > written_hi)
            written_hi = disp_pos + 1;
        if (disp_pos + 1 >= cnt_use) begin
            disp_pos  = 0;
            first_trk = 1'b0;
            n_pixels++;
        end else begin
            disp_pos++;
        end
    endtask

    // Finish the current pixel; row start and intensity past disparity zero
    // are random since the block ignores them there.
    task automatic feed_pixel(input logic [INT_W-1:0] inten, input logic rs);
        do begin
            feed(pick_cost(),
                 (disp_pos == 0) ? inten : INT_W'($urandom_range(0, 65535)),
                 (disp_pos == 0) ? rs : 1'($urandom_range(0, 1)));
        end while (disp_pos != 0);
    endtask

    // Drop valid, wait for every pending result, then let the pipe drain.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_DISPARITY_COUNT)
            cnt_use = count_used(data[CNT_CFG_W-1:0]);
        n_writes++;
    endtask

    // Receiver: random stalls, stall-free stretches, and the long hold-off
    // when asked. The hold-off counts its own cycles so the sender keeps
    // offering meanwhile and the block backs up into its input.
    initial begin : receiver
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                n_holds++;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
                else if ($urandom_range(0, 99) < 3)
                    free_left = $urandom_range(50, 200);
                else
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: too long without any handshake on any channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired, %0d results still pending", $time, pending);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int                   phase;
        int                   n_pix;
        logic [CFG_DATA_W-1:0] cnt_word;
        logic [PEN_W-1:0]     small_pen;
        logic [PEN_W-1:0]     large_pen;
        logic [CFG_DATA_W-1:0] scale_word;

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // ---- directed: 4-wide pixels keep the corner cases short ----
        write_reg(CFG_DISPARITY_COUNT, 16'd4);
        write_reg(CFG_PENALTY_SMALL, 16'd3);
        write_reg(CFG_PENALTY_LARGE, 16'd20);
        write_reg(CFG_SCALE_LARGE, 16'd0);
        // a write to an index with no register must change nothing
        write_reg(CFG_UNUSED, 16'hFFFF);

        // first pixel after reset, row start low: result is the raw cost,
        // including the cost extremes
        feed(16'd0, 16'd100, 1'b0);
        feed(16'hFFFF, 16'd0, 1'b0);
        feed(16'd1, 16'd0, 1'b0);
        feed(16'd2, 16'd0, 1'b0);
        // plain aggregation; row start and intensity mid-pixel are ignored
        feed(16'd5, 16'd90, 1'b0);
        feed(16'd0, 16'hFFFF, 1'b1);
        feed(16'd9, 16'd0, 1'b1);
        feed(16'd40, 16'd0, 1'b0);

        // narrow to 2, then widen back: entries 2 and 3 are stale and can
        // undercut the previous minimum
        settle();
        write_reg(CFG_DISPARITY_COUNT, 16'd2);
        feed(16'd1000, 16'd90, 1'b0);
        feed(16'd1200, 16'd0, 1'b0);
        settle();
        write_reg(CFG_DISPARITY_COUNT, 16'd4);
        feed(16'd7, 16'd90, 1'b0);
        feed(16'd7, 16'd0, 1'b0);
        feed(16'd7, 16'd0, 1'b0);
        feed(16'd7, 16'd0, 1'b0);

        // explicit row start
        feed(16'd1, 16'd50, 1'b1);
        feed(16'd2, 16'd0, 1'b0);
        feed(16'd3, 16'd0, 1'b0);
        feed(16'd4, 16'd0, 1'b0);

        // count shrinks with the pixel half done: the next item closes it
        feed(16'd0, 16'd60, 1'b0);
        feed(16'd0, 16'd0, 1'b0);
        settle();
        write_reg(CFG_DISPARITY_COUNT, 16'd2);
        feed(16'd5, 16'd0, 1'b0);

        // gradient scaling with a zero large penalty, count code zero
        settle();
        write_reg(CFG_SCALE_LARGE, 16'd1);
        write_reg(CFG_PENALTY_LARGE, 16'd0);
        write_reg(CFG_DISPARITY_COUNT, 16'd0);
        feed(16'hFFFF, 16'd0, 1'b0);
        feed(16'hFFFF, 16'hFFFF, 1'b0);

        // largest penalties: unit gradient, then the widest gradient
        settle();
        write_reg(CFG_PENALTY_LARGE, 16'hFFFF);
        write_reg(CFG_PENALTY_SMALL, 16'hFFFF);
        write_reg(CFG_DISPARITY_COUNT, 16'd2);
        feed(16'd0, 16'hFFFF, 1'b0);
        feed(16'hFFFF, 16'd0, 1'b0);
        feed(16'hFFFF, 16'd0, 1'b0);
        feed(16'd0, 16'd0, 1'b0);

        // ---- random phases, new settings between them ----
        phase = 0;
        while (n_items < N_ITEMS) begin
            settle();
            small_pen  = pick_penalty();
            large_pen  = pick_penalty();
            scale_word = CFG_DATA_W'($urandom_range(0, 65535));
            cnt_word   = CFG_DATA_W'($urandom_range(0, 65535));
            cnt_word[CNT_CFG_W-1:0] = pick_count();
            // open with the register extremes
            case (phase)
                0: begin
                    small_pen = '1;
                    large_pen = '1;
                    scale_word[0] = 1'b0;
                    cnt_word[CNT_CFG_W-1:0] = CNT_CFG_W'(DISP_MAX);
                end
                1: begin
                    small_pen = '0;
                    large_pen = 16'd1;
                    scale_word[0] = 1'b1;
                    cnt_word[CNT_CFG_W-1:0] = '1;
                end
                2: begin
                    small_pen = '1;
                    large_pen = '1;
                    scale_word[0] = 1'b1;
                    cnt_word[CNT_CFG_W-1:0] = 7'd1;
                end
                default: ;
            endcase
            if (phase < 3 || $urandom_range(0, 3) != 0)
                write_reg(CFG_PENALTY_SMALL, small_pen);
            if (phase < 3 || $urandom_range(0, 3) != 0)
                write_reg(CFG_PENALTY_LARGE, large_pen);
            if (phase < 3 || $urandom_range(0, 2) != 0)
                write_reg(CFG_SCALE_LARGE, scale_word);
            // mid-pixel the count may only shrink, so no read goes stale
            if (disp_pos == 0 || count_used(cnt_word[CNT_CFG_W-1:0]) <= cnt_use)
                write_reg(CFG_DISPARITY_COUNT, cnt_word);

            // two phases run the long hold-off with the sender at full rate
            if (phase == 4 || phase == 40) begin
                hold_req = 1'b1;
                dense    = 1'b1;
            end else begin
                dense = ($urandom_range(0, 3) == 0);
            end

            n_pix = (cnt_use > 16) ? $urandom_range(1, 3) : $urandom_range(2, 12);
            if (disp_pos != 0)
                feed_pixel('0, 1'b0);
            repeat (n_pix) feed_pixel(next_intensity(), $urandom_range(0, 9) == 0);
            // sometimes stop inside a pixel so the next settings land mid-pixel
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    feed(pick_cost(), INT_W'($urandom_range(0, 65535)), 1'b0);
            phase++;
        end

        settle();
        $display("Covered %0d cost items in %0d pixels; %0d register writes over %0d phases",
                 n_items, n_pixels, n_writes, phase);
        $display("%0d results compared; %0d long receiver hold-offs of %0d cycles",
                 checked, n_holds, HOLD_CYCLES);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
